// ===== src/olki_pkg.sv =====
package olki_pkg;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_BEFORE = 2'd1,
        FUNC_AFTER  = 2'd2,
        FUNC_DUMP   = 2'd3
    } func_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        func_t       func;
        logic [63:0] target_key;
        logic [63:0] new_key;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_count;
        logic [63:0] entry_value;
        logic        entry_valid;
        logic        last;
    } out_item_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_BEFORE,
        CELL_AFTER,
        CELL_APPEND,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     pre_cur;
        logic     pre_prev;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_INS,
        S_DUMP
    } state_t;

endpackage

// ===== src/olki_cell.sv =====
module olki_cell #(
    parameter int DEPTH     = 32,
    parameter int KEY_WIDTH = 64,
    parameter int IDX       = 0,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  olki_pkg::cell_cmd_t   cmd,
    input  logic [CW-1:0]         cnt,
    input  logic [KEY_WIDTH-1:0]  target,
    input  logic [KEY_WIDTH-1:0]  new_key,
    input  logic [KEY_WIDTH-1:0]  left_key,
    input  logic [KEY_WIDTH-1:0]  right_key,
    input  logic [KEY_WIDTH-1:0]  head_key,
    output logic [KEY_WIDTH-1:0]  key,
    output logic                  match
);
    import olki_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 in_list;
    logic                 at_end;
    logic                 at_tail;

    assign in_list = CW'(IDX) < cnt;
    assign at_end  = CW'(IDX) == cnt;
    assign at_tail = CW'(IDX) == (cnt - CW'(1));

    always_comb
    begin
        key_next   = key_reg;
        match_next = match_reg;
        case (cmd.op)
            CELL_CMP:
            begin
                match_next = in_list && (key_reg == target);
            end
            CELL_BEFORE:
            begin
                if (cmd.pre_cur)
                    key_next = left_key;
                else if (match_reg)
                    key_next = new_key;
            end
            CELL_AFTER:
            begin
                if (cmd.pre_prev)
                    key_next = left_key;
                else if (cmd.pre_cur)
                    key_next = new_key;
            end
            CELL_APPEND:
            begin
                if (at_end)
                    key_next = new_key;
            end
            CELL_ROTATE:
            begin
                if (at_tail)
                    key_next = head_key;
                else if (in_list)
                    key_next = right_key;
            end
            default:
            begin
                key_next = key_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        match_reg <= match_next;
    end

    assign key   = key_reg;
    assign match = match_reg;

endmodule

// ===== src/ordered_list_keyed_insert.sv =====
// Ordered key list of up to DEPTH keys held in a row of cells, one key per
// cell. An item is taken only when the block is idle. Append loads its result
// into the output register from the insert state, once the output is free.
// Insert before/after first passes through a compare step in which every cell
// compares its key with the target, and then an insert step in which the first
// match is located and the cells above it shift up by one. The block is idle
// again once the result is loaded. Dump returns one result per cycle while the
// output is not stalled, by rotating the stored keys through cell 0. It gives
// one result per stored key, or a single result for an empty list, and the list
// is left in its original order. A stall on the output holds the block in its
// insert or dump state. Keys are the low KEY_WIDTH bits of the input keys.
module ordered_list_keyed_insert #(
    parameter int DEPTH     = 32,
    parameter int KEY_WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  olki_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output olki_pkg::out_item_t out_item
);
    import olki_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg;
    state_t               state_next;
    func_t                func_reg;
    logic [KEY_WIDTH-1:0] tgt_reg;
    logic [KEY_WIDTH-1:0] new_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        cnt_next;
    logic [CW-1:0]        dcnt_reg;
    logic [CW-1:0]        dcnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_item_t            out_item_reg;
    out_item_t            out_item_next;

    logic [KEY_WIDTH-1:0] keys [DEPTH];
    logic [DEPTH-1:0]     match_vec;
    logic [DEPTH-1:0]     pre_incl;
    logic [DEPTH-1:0]     pre_excl;
    logic [DEPTH-1:0]     pre_excl2;
    cell_op_t             cell_op;
    logic                 out_free;
    logic                 found;
    logic                 full;
    logic [1:0]           ins_status;
    logic                 dump_last;
    logic                 load_out;
    logic                 grow;

    always_comb
    begin
        pre_incl = match_vec;
        for (int s = 1; s < DEPTH; s = s * 2)
            pre_incl = pre_incl | (pre_incl << s);
    end

    assign pre_excl  = pre_incl << 1;
    assign pre_excl2 = pre_incl << 2;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            cell_cmd_t            cmd;
            logic [KEY_WIDTH-1:0] left_key;
            logic [KEY_WIDTH-1:0] right_key;

            assign cmd.op       = cell_op;
            assign cmd.pre_cur  = pre_excl[gi];
            assign cmd.pre_prev = pre_excl2[gi];

            if (gi == 0)
            begin : g_first
                assign left_key = '0;
            end
            else
            begin : g_mid
                assign left_key = keys[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_key = '0;
            end
            else
            begin : g_inner
                assign right_key = keys[gi+1];
            end

            olki_cell #(
                .DEPTH     (DEPTH),
                .KEY_WIDTH (KEY_WIDTH),
                .IDX       (gi),
                .CW        (CW)
            ) u_cell (
                .clk       (clk),
                .cmd       (cmd),
                .cnt       (cnt_reg),
                .target    (tgt_reg),
                .new_key   (new_reg),
                .left_key  (left_key),
                .right_key (right_key),
                .head_key  (keys[0]),
                .key       (keys[gi]),
                .match     (match_vec[gi])
            );
        end
    endgenerate

    assign out_free  = !out_valid_reg || !out_stall;
    assign found     = pre_incl[DEPTH-1];
    assign full      = cnt_reg == CW'(DEPTH);
    assign dump_last = (cnt_reg == '0) || (dcnt_reg == (cnt_reg - CW'(1)));

    always_comb
    begin
        if (func_reg == FUNC_APPEND)
            ins_status = full ? ST_FULL : ST_OK;
        else if (!found)
            ins_status = ST_NOT_FOUND;
        else if (full)
            ins_status = ST_FULL;
        else
            ins_status = ST_OK;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.func == FUNC_DUMP)
                        state_next = S_DUMP;
                    else if (in_item.func == FUNC_APPEND)
                        state_next = S_INS;
                    else
                        state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_INS;
            end
            S_INS:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            S_DUMP:
            begin
                if (out_free && dump_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cell_op       = CELL_HOLD;
        load_out      = 1'b0;
        grow          = 1'b0;
        out_item_next = out_item_reg;
        dcnt_next     = dcnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                dcnt_next = '0;
            end
            S_CMP:
            begin
                cell_op = CELL_CMP;
            end
            S_INS:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (ins_status == ST_OK)
                    begin
                        grow = 1'b1;
                        case (func_reg)
                            FUNC_BEFORE: cell_op = CELL_BEFORE;
                            FUNC_AFTER:  cell_op = CELL_AFTER;
                            default:     cell_op = CELL_APPEND;
                        endcase
                    end
                    out_item_next.status      = ins_status;
                    out_item_next.entry_count = 6'(cnt_reg + (grow ? CW'(1) : CW'(0)));
                    out_item_next.entry_value = '0;
                    out_item_next.entry_valid = 1'b0;
                    out_item_next.last        = 1'b1;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    dcnt_next = dcnt_reg + CW'(1);
                    if (cnt_reg != '0)
                        cell_op = CELL_ROTATE;
                    out_item_next.status      = ST_OK;
                    out_item_next.entry_count = 6'(cnt_reg);
                    out_item_next.entry_value = (cnt_reg != '0) ? 64'(keys[0]) : '0;
                    out_item_next.entry_valid = cnt_reg != '0;
                    out_item_next.last        = dump_last;
                end
            end
            default:
            begin
                cell_op = CELL_HOLD;
            end
        endcase
    end

    assign cnt_next       = grow ? cnt_reg + CW'(1) : cnt_reg;
    assign out_valid_next = load_out ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            func_reg <= in_item.func;
            tgt_reg  <= in_item.target_key[KEY_WIDTH-1:0];
            new_reg  <= in_item.new_key[KEY_WIDTH-1:0];
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== test/olki_list_checker.sv =====
`timescale 1ns / 1ps

module olki_list_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  olki_pkg::in_item_t  in_item,
    input  logic                out_valid,
    input  logic                out_stall,
    input  olki_pkg::out_item_t out_item,
    output int                  errors,
    output int                  waiting
);
    import olki_pkg::*;

    localparam int SLOTS = 32;

    logic [63:0] list_keys [SLOTS];
    int          list_len = 0;
    out_item_t   due_results [$];
    int          fail_cnt = 0;
    int          due_cnt = 0;

    assign errors  = fail_cnt;
    assign waiting = due_cnt;

    task automatic report_mismatch(input string msg);
        fail_cnt++;
        if (fail_cnt <= 30)
        begin
            $display("%0t ns: mismatch: %s", $time, msg);
        end
    endtask

    task automatic place_key(input int pos, input logic [63:0] key);
        for (int i = list_len; i > pos; i--)
        begin
            list_keys[i] = list_keys[i - 1];
        end
        list_keys[pos] = key;
        list_len++;
    endtask

    task automatic apply_list_op(input in_item_t it);
        out_item_t  r;
        int         hit;
        logic [1:0] st;
        r = '0;
        r.last = 1'b1;
        st = ST_OK;
        hit = -1;
        if (it.func == FUNC_DUMP)
        begin
            if (list_len == 0)
            begin
                due_results.push_back(r);
            end
            else
            begin
                for (int i = 0; i < list_len; i++)
                begin
                    r.status      = ST_OK;
                    r.entry_count = 6'(list_len);
                    r.entry_value = list_keys[i];
                    r.entry_valid = 1'b1;
                    r.last        = (i == list_len - 1);
                    due_results.push_back(r);
                end
            end
        end
        else
        begin
            if (it.func == FUNC_APPEND)
            begin
                if (list_len < SLOTS)
                    place_key(list_len, it.new_key);
                else
                    st = ST_FULL;
            end
            else
            begin
                // first match wins on duplicate keys
                for (int i = 0; i < list_len; i++)
                begin
                    if (hit < 0 && list_keys[i] == it.target_key)
                        hit = i;
                end
                if (hit < 0)
                    st = ST_NOT_FOUND;
                else if (list_len >= SLOTS)
                    st = ST_FULL;
                else
                    place_key(hit + ((it.func == FUNC_AFTER) ? 1 : 0), it.new_key);
            end
            r.status      = st;
            r.entry_count = 6'(list_len);
            due_results.push_back(r);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected item %h", got));
        end
        else
        begin
            want = due_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count %0d, want %0d",
                                          got.entry_count, want.entry_count));
            if (got.entry_value !== want.entry_value)
                report_mismatch($sformatf("entry_value %h, want %h",
                                          got.entry_value, want.entry_value));
            if (got.entry_valid !== want.entry_valid)
                report_mismatch($sformatf("entry_valid %b, want %b",
                                          got.entry_valid, want.entry_valid));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_len = 0;
            due_results.delete();
            due_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result(out_item);
            if (in_valid && !in_stall)
                apply_list_op(in_item);
            due_cnt <= due_results.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import olki_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    int        err_cnt;
    int        due_cnt;

    logic      tx_calm = 1'b0;
    logic      rx_calm = 1'b0;
    logic      hold_go = 1'b0;
    logic      hold_done = 1'b0;

    logic [63:0] key_pool [12];

    ordered_list_keyed_insert uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    olki_list_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .errors    (err_cnt),
        .waiting   (due_cnt)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] any_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, 11)];
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_op(input func_t f, input logic [63:0] tgt, input logic [63:0] key);
        in_item_t it;
        it.func       = f;
        it.target_key = tgt;
        it.new_key    = key;
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_cnt != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // receiver side
    initial
    begin : rx_side
        int len;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
            end
            if ($urandom_range(0, 49) == 0)
                rx_calm = !rx_calm;
            len = rx_calm ? 0 : pick_gap();
            if (len == 0)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] zk;
        logic [63:0] fk;
        logic [63:0] pk;
        logic [63:0] qk;
        func_t       f;
        int          pick;
        int          waited;
        zk = 64'h0;
        fk = '1;
        pk = 64'h0123_4567_89AB_CDEF;
        qk = 64'hFEDC_BA98_7654_3210;
        foreach (key_pool[i])
            key_pool[i] = {$urandom, $urandom};
        key_pool[0] = zk;
        key_pool[1] = fk;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list cases
        send_op(FUNC_DUMP, zk, zk);
        send_op(FUNC_BEFORE, fk, pk);
        send_op(FUNC_AFTER, zk, pk);
        // build a short list with a duplicate key
        send_op(FUNC_APPEND, fk, zk);
        send_op(FUNC_APPEND, zk, fk);
        send_op(FUNC_BEFORE, fk, pk);
        send_op(FUNC_AFTER, zk, qk);
        send_op(FUNC_APPEND, qk, zk);
        send_op(FUNC_AFTER, zk, fk);
        send_op(FUNC_BEFORE, zk, 64'hA5A5_A5A5_A5A5_A5A5);
        send_op(FUNC_BEFORE, 64'h5555_5555_5555_5555, pk);
        send_op(FUNC_DUMP, fk, fk);

        for (int n = 0; n < 340; n++)
        begin
            if (n % 30 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            if (n == 60)
                hold_go = 1'b1;
            if (n == 180)
                wait_drained();
            pick = $urandom_range(0, 19);
            if (pick < 6)
                f = FUNC_APPEND;
            else if (pick < 11)
                f = FUNC_BEFORE;
            else if (pick < 16)
                f = FUNC_AFTER;
            else
                f = FUNC_DUMP;
            send_op(f, any_key(), any_key());
        end

        // full list cases
        wait_drained();
        send_op(FUNC_APPEND, zk, qk);
        send_op(FUNC_BEFORE, zk, pk);
        send_op(FUNC_AFTER, fk, pk);
        send_op(FUNC_BEFORE, 64'h5A5A_5A5A_5A5A_5A5A, qk);
        send_op(FUNC_DUMP, zk, zk);

        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (due_cnt != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (err_cnt == 0 && due_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== ordered_list_keyed_insert.f =====
src/olki_pkg.sv
src/olki_cell.sv
src/ordered_list_keyed_insert.sv
test/olki_list_checker.sv
test/tb_top.sv
